@@ design/lham_pkg.sv @@
// Package: commands, status codes and sequencer states of the line heap allocator.
`default_nettype none
package lham_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_SWEEP = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOMEM    = 3'd2,
    ST_NOT_HEAP = 3'd3,
    ST_MARKED   = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_DECODE,
    S_A_RD,
    S_A_WAIT,
    S_A_CHK,
    S_A_HEAD,
    S_A_SH_RD,
    S_A_SH_WAIT,
    S_A_SH_WR,
    S_F_BACK_RD,
    S_F_BACK_WAIT,
    S_F_FWD_RD,
    S_F_FWD_WAIT,
    S_M_RD,
    S_M_WAIT,
    S_M_SET,
    S_W_RD,
    S_W_WAIT,
    S_W_CLR,
    S_DONE,
    S_OUT
  } state_e;

  localparam int unsigned CFG_HEAP_BASE    = 0;
  localparam int unsigned CFG_USABLE_LINES = 1;
  localparam int unsigned LINE_SHIFT       = 5;

endpackage
`default_nettype wire

@@ design/lham_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module lham_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ design/line_heap_allocator_marker_unit.sv @@
// Top level: line heap allocator with head and mark bitmaps and a fragment table.
// Usage:
//  Commands arrive on the in channel (cmd_i, request_bytes_i, address_i) under
//  in_valid_i/in_ready_o; each gives one result beat on the out channel under
//  out_valid_o/out_ready_i. Registers are written on the cfg channel
//  (index 0 heap base, index 1 usable lines); the user must write them only
//  while the block is idle, which the block does not enforce. One command at
//  a time: in_ready_o is low from acceptance until the result beat is taken. A
//  stalled receiver holds the result and the block. Bitmaps and the fragment
//  table live in single-port RAMs, one access per cycle, so the bitmap walks
//  set the run time: allocate reads, waits and checks per fragment probed,
//  writes a head bit per line taken, and reads, waits and writes per fragment
//  shifted when one is used up; find reads and waits per line walked back to
//  the head and forward to the end; mark adds a mark write per line marked;
//  sweep reads, waits and clears per usable line and clears a mark per line
//  beyond them. Reset starts a clearing pass over all HEAP_LINES lines (heads
//  set, marks cleared); in_ready_o stays low for it, cfg writes are taken as ever.
`default_nettype none
module line_heap_allocator_marker_unit #(
  parameter int unsigned HEAP_LINES    = 4096,
  parameter int unsigned MAX_FRAGMENTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] request_bytes_i,
  input  wire logic [63:0] address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [63:0]      object_address_o,
  output logic [12:0]      object_lines_o,
  output logic [12:0]      free_lines_o,
  output logic [8:0]       free_fragments_o
);
  localparam int unsigned LW = $clog2(HEAP_LINES);
  localparam int unsigned CW = LW + 1;
  localparam int unsigned FW = $clog2(MAX_FRAGMENTS);
  localparam int unsigned NW = FW + 1;

  lham_pkg::state_e state_q, state_d;

  logic [63:0] base_q;
  logic [12:0] usable_q;
  logic        frag0_fix_q, frag0_fix_d;

  logic [1:0]  cmd_q, cmd_d;
  logic [32:0] need_q, need_d;
  logic [63:0] addr_q, addr_d;
  logic [CW-1:0] line_q, line_d, start_q, start_d, len_q, len_d;
  logic [CW-1:0] fst_q, fst_d, fln_q, fln_d, run_q, run_d;
  logic [CW-1:0] free_q, free_d;
  logic [NW-1:0] k_q, k_d, cnt_q, cnt_d, fcount_q, fcount_d;
  logic        inrun_q, inrun_d, over_q, over_d;
  logic [2:0]  st_q, st_d;
  logic [63:0] oaddr_q, oaddr_d;
  logic [12:0] olines_q, olines_d, oflines_q, oflines_d;
  logic [8:0]  offr_q, offr_d;

  // RAM ports
  logic          h_we, m_we, f_we;
  logic [LW-1:0] h_addr, m_addr;
  logic          h_wd, m_wd, h_rd, m_rd;
  logic [FW-1:0] f_addr;
  logic [2*CW-1:0] f_wd, f_rd;
  logic [CW-1:0] f_rd_st, f_rd_ln;

  lham_ram #(.Width(1), .Depth(HEAP_LINES)) u_head (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wd), .rdata_o(h_rd));
  lham_ram #(.Width(1), .Depth(HEAP_LINES)) u_mark (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wd), .rdata_o(m_rd));
  lham_ram #(.Width(2*CW), .Depth(MAX_FRAGMENTS)) u_frag (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(f_wd), .rdata_o(f_rd));

  assign f_rd_st = f_rd[2*CW-1:CW];
  assign f_rd_ln = f_rd[CW-1:0];

  logic [CW-1:0] u_lines;
  assign u_lines = ({{(CW > 13 ? CW-13 : 0){1'b0}}, usable_q} > CW'(HEAP_LINES))
                 ? CW'(HEAP_LINES) : CW'(usable_q);

  logic [63:0] off;
  logic [58:0] off_line;
  logic        in_heap;
  assign off      = addr_q - base_q;
  assign off_line = off[63:lham_pkg::LINE_SHIFT];
  assign in_heap  = (addr_q >= base_q) && (off_line < 59'(u_lines));

  // alloc helpers
  logic [33:0] fit_end;
  assign fit_end = 34'(fst_q) + 34'(need_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == lham_pkg::S_IDLE);
  assign out_valid_o = (state_q == lham_pkg::S_OUT);
  assign status_o         = st_q;
  assign object_address_o = oaddr_q;
  assign object_lines_o   = olines_q;
  assign free_lines_o     = oflines_q;
  assign free_fragments_o = offr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lham_pkg::S_CLEAR;
      base_q      <= '0;
      usable_q    <= 13'd4096;
      frag0_fix_q <= 1'b1;
      fcount_q    <= NW'(1);
      line_q      <= '0;
    end else begin
      state_q     <= state_d;
      frag0_fix_q <= frag0_fix_d;
      fcount_q    <= fcount_d;
      line_q      <= line_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == 1'(lham_pkg::CFG_HEAP_BASE)) base_q <= cfg_data_i;
        else usable_q <= cfg_data_i[12:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; need_q <= need_d; addr_q <= addr_d;
    start_q <= start_d; len_q <= len_d; fst_q <= fst_d; fln_q <= fln_d;
    run_q <= run_d; free_q <= free_d; k_q <= k_d; cnt_q <= cnt_d;
    inrun_q <= inrun_d; over_q <= over_d; st_q <= st_d; oaddr_q <= oaddr_d;
    olines_q <= olines_d; oflines_q <= oflines_d; offr_q <= offr_d;
  end

  always_comb begin
    state_d = state_q; frag0_fix_d = frag0_fix_q; fcount_d = fcount_q;
    cmd_d = cmd_q; need_d = need_q; addr_d = addr_q; line_d = line_q;
    start_d = start_q; len_d = len_q; fst_d = fst_q; fln_d = fln_q;
    run_d = run_q; free_d = free_q; k_d = k_q; cnt_d = cnt_q;
    inrun_d = inrun_q; over_d = over_q; st_d = st_q; oaddr_d = oaddr_q;
    olines_d = olines_q; oflines_d = oflines_q; offr_d = offr_q;
    h_we = 1'b0; h_addr = line_q[LW-1:0]; h_wd = 1'b1;
    m_we = 1'b0; m_addr = line_q[LW-1:0]; m_wd = 1'b0;
    f_we = 1'b0; f_addr = k_q[FW-1:0]; f_wd = '0;

    case (state_q)
      lham_pkg::S_CLEAR: begin
        h_we = 1'b1; m_we = 1'b1;
        line_d = line_q + CW'(1);
        if (line_q == CW'(HEAP_LINES - 1)) begin
          line_d = '0;
          state_d = lham_pkg::S_IDLE;
        end
      end
      lham_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = cmd_i;
          need_d = (request_bytes_i == '0) ? '0
                 : (33'(request_bytes_i) + 33'd32) >> lham_pkg::LINE_SHIFT;
          addr_d = address_i;
          st_d = lham_pkg::ST_OK; oaddr_d = '0; olines_d = '0;
          oflines_d = '0; offr_d = '0;
          state_d = lham_pkg::S_DECODE;
        end
      end
      lham_pkg::S_DECODE: begin
        // entry zero holds the whole heap from reset until first rewritten
        if (frag0_fix_q) begin
          f_we = 1'b1; f_addr = '0;
          f_wd = {CW'(0), CW'(HEAP_LINES < 4096 ? HEAP_LINES : 4096)};
        end
        k_d = '0;
        case (lham_pkg::cmd_e'(cmd_q))
          lham_pkg::CMD_ALLOC: begin
            frag0_fix_d = 1'b0;
            if (need_q == '0) begin
              st_d = lham_pkg::ST_ZERO; state_d = lham_pkg::S_OUT;
            end else state_d = lham_pkg::S_A_RD;
          end
          lham_pkg::CMD_FIND, lham_pkg::CMD_MARK: begin
            if (!in_heap) begin
              st_d = lham_pkg::ST_NOT_HEAP; state_d = lham_pkg::S_OUT;
            end else begin
              line_d = CW'(off_line);
              state_d = lham_pkg::S_F_BACK_RD;
            end
          end
          default: begin
            frag0_fix_d = 1'b0;
            line_d = '0; cnt_d = '0; free_d = '0; inrun_d = 1'b0; over_d = 1'b0;
            state_d = lham_pkg::S_W_RD;
          end
        endcase
      end
      // allocate: first fit over the fragment table
      lham_pkg::S_A_RD: begin
        if (k_q >= fcount_q || k_q == NW'(MAX_FRAGMENTS)) begin
          st_d = lham_pkg::ST_NOMEM; state_d = lham_pkg::S_OUT;
        end else state_d = lham_pkg::S_A_WAIT;
      end
      lham_pkg::S_A_WAIT: begin
        fst_d = f_rd_st; fln_d = f_rd_ln;
        state_d = lham_pkg::S_A_CHK;
      end
      lham_pkg::S_A_CHK: begin
        if (33'(fln_q) >= need_q && fit_end <= 34'(u_lines)) begin
          oaddr_d  = base_q + (64'(fst_q) << lham_pkg::LINE_SHIFT);
          olines_d = 13'(need_q);
          line_d   = fst_q;
          len_d    = CW'(need_q);
          state_d  = lham_pkg::S_A_HEAD;
        end else begin
          k_d = k_q + NW'(1);
          state_d = lham_pkg::S_A_RD;
        end
      end
      lham_pkg::S_A_HEAD: begin
        h_we = 1'b1; h_wd = (line_q == fst_q);
        line_d = line_q + CW'(1);
        if (line_q + CW'(1) == CW'(fit_end)) begin
          if (33'(fln_q) == need_q) begin
            fcount_d = fcount_q - NW'(1);
            state_d = lham_pkg::S_A_SH_RD;
          end else begin
            f_we = 1'b1;
            f_wd = {CW'(fit_end), fln_q - CW'(need_q)};
            state_d = lham_pkg::S_OUT;
          end
        end
      end
      lham_pkg::S_A_SH_RD: begin
        // fcount_q already decremented: shift while k < fcount
        if (k_q >= fcount_q || k_q + NW'(1) >= NW'(MAX_FRAGMENTS)) state_d = lham_pkg::S_OUT;
        else begin
          f_addr = FW'(k_q + NW'(1));
          state_d = lham_pkg::S_A_SH_WAIT;
        end
      end
      lham_pkg::S_A_SH_WAIT: begin
        f_addr = FW'(k_q + NW'(1));
        state_d = lham_pkg::S_A_SH_WR;
      end
      lham_pkg::S_A_SH_WR: begin
        f_we = 1'b1; f_wd = f_rd;
        k_d = k_q + NW'(1);
        state_d = lham_pkg::S_A_SH_RD;
      end
      // find: walk back to the head, then forward to the end
      lham_pkg::S_F_BACK_RD: state_d = lham_pkg::S_F_BACK_WAIT;
      lham_pkg::S_F_BACK_WAIT: begin
        if (h_rd || line_q == '0) begin
          start_d = line_q;
          len_d = CW'(1);
          line_d = line_q + CW'(1);
          state_d = lham_pkg::S_F_FWD_RD;
        end else begin
          line_d = line_q - CW'(1);
          state_d = lham_pkg::S_F_BACK_RD;
        end
      end
      lham_pkg::S_F_FWD_RD: begin
        if (line_q >= u_lines) state_d = lham_pkg::S_M_RD;
        else state_d = lham_pkg::S_F_FWD_WAIT;
      end
      lham_pkg::S_F_FWD_WAIT: begin
        if (h_rd) state_d = lham_pkg::S_M_RD;
        else begin
          len_d = len_q + CW'(1);
          line_d = line_q + CW'(1);
          state_d = lham_pkg::S_F_FWD_RD;
        end
      end
      lham_pkg::S_M_RD: begin
        oaddr_d  = base_q + (64'(start_q) << lham_pkg::LINE_SHIFT);
        olines_d = 13'(len_q);
        m_addr = start_q[LW-1:0];
        line_d = start_q;
        if (cmd_q == lham_pkg::CMD_MARK) state_d = lham_pkg::S_M_WAIT;
        else state_d = lham_pkg::S_OUT;
      end
      lham_pkg::S_M_WAIT: begin
        if (m_rd) begin
          st_d = lham_pkg::ST_MARKED; state_d = lham_pkg::S_OUT;
        end else state_d = lham_pkg::S_M_SET;
      end
      lham_pkg::S_M_SET: begin
        m_we = 1'b1; m_wd = 1'b1;
        line_d = line_q + CW'(1);
        if (line_q + CW'(1) == start_q + len_q) state_d = lham_pkg::S_OUT;
      end
      // sweep: one line per pass
      lham_pkg::S_W_RD: begin
        if (line_q >= u_lines) state_d = lham_pkg::S_DONE;
        else state_d = lham_pkg::S_W_WAIT;
      end
      lham_pkg::S_W_WAIT: state_d = lham_pkg::S_W_CLR;
      lham_pkg::S_W_CLR: begin
        m_we = 1'b1; m_wd = 1'b0;
        line_d = line_q + CW'(1);
        state_d = lham_pkg::S_W_RD;
        if (!m_rd) begin
          h_we = 1'b1; h_wd = 1'b1;
          free_d = free_q + CW'(1);
          if (!inrun_q) begin
            run_d = line_q; inrun_d = 1'b1;
          end
        end
        if (inrun_q && m_rd) begin
          inrun_d = 1'b0;
          if (cnt_q < NW'(MAX_FRAGMENTS)) begin
            f_we = 1'b1; f_addr = cnt_q[FW-1:0]; f_wd = {run_q, line_q - run_q};
            cnt_d = cnt_q + NW'(1);
          end else over_d = 1'b1;
        end
      end
      lham_pkg::S_DONE: begin
        if (inrun_q) begin
          inrun_d = 1'b0;
          if (cnt_q < NW'(MAX_FRAGMENTS)) begin
            f_we = 1'b1; f_addr = cnt_q[FW-1:0]; f_wd = {run_q, line_q - run_q};
            cnt_d = cnt_q + NW'(1);
          end else over_d = 1'b1;
        end else begin
          // marks beyond usable lines cleared as well
          if (line_q < CW'(HEAP_LINES)) begin
            m_we = 1'b1; m_wd = 1'b0;
            line_d = line_q + CW'(1);
          end else begin
            fcount_d = cnt_q;
            offr_d = 9'(cnt_q);
            oflines_d = 13'(free_q);
            st_d = over_q ? lham_pkg::ST_OVERFLOW : lham_pkg::ST_OK;
            state_d = lham_pkg::S_OUT;
          end
        end
      end
      lham_pkg::S_OUT: begin
        if (out_ready_i) state_d = lham_pkg::S_IDLE;
      end
      default: state_d = lham_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench top: randomised command traffic with a self-checking heap allocator scoreboard.
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned HEAP_LINES    = 4096;
  localparam int unsigned MAX_FRAGMENTS = 256;
  localparam longint unsigned CYCLE_LIMIT = 40000000;

  typedef struct {
    lham_pkg::status_e status;
    logic [63:0]     obj_addr;
    logic [12:0]     obj_lines;
    logic [12:0]     free_lines;
    logic [8:0]      free_frags;
  } heap_result_t;

  class heap_scoreboard;
    bit [63:0]   base;
    bit [12:0]   usable;
    bit          heads[HEAP_LINES];
    bit          marks[HEAP_LINES];
    int unsigned frag_start[MAX_FRAGMENTS];
    int unsigned frag_len[MAX_FRAGMENTS];
    int unsigned frag_count;
    heap_result_t expected_q[$];
    int unsigned  errors;

    function new();
      base = '0;
      usable = 13'd4096;
      foreach (heads[i]) heads[i] = 1'b1;
      foreach (marks[i]) marks[i] = 1'b0;
      foreach (frag_start[i]) begin
        frag_start[i] = 0;
        frag_len[i] = 0;
      end
      frag_len[0] = span();
      frag_count = 1;
      errors = 0;
    endfunction

    function int unsigned span();
      return (usable > HEAP_LINES) ? HEAP_LINES : int'(usable);
    endfunction

    function void write_reg(bit idx, bit [63:0] data);
      if (idx == 1'(lham_pkg::CFG_HEAP_BASE)) base = data;
      else usable = data[12:0];
    endfunction

    function heap_result_t note_command(lham_pkg::cmd_e c, bit [31:0] req, bit [63:0] addr);
      heap_result_t r;
      longint unsigned need, st, ln, off;
      int unsigned u, s, n, ln_i, cnt;
      bit over;
      u = span();
      r = '{lham_pkg::ST_OK, '0, '0, '0, '0};
      case (c)
        lham_pkg::CMD_ALLOC: begin
          need = (longint'(req) + 32) / 32;
          if (req == 0) r.status = lham_pkg::ST_ZERO;
          else begin
            r.status = lham_pkg::ST_NOMEM;
            for (int k = 0; k < frag_count && k < MAX_FRAGMENTS; k++) begin
              st = frag_start[k];
              ln = frag_len[k];
              if (ln >= need && st + need <= u) begin
                heads[st] = 1'b1;
                for (longint unsigned i = st + 1; i < st + need; i++) heads[i] = 1'b0;
                if (ln == need) begin
                  for (int i = k; i + 1 < frag_count && i + 1 < MAX_FRAGMENTS; i++) begin
                    frag_start[i] = frag_start[i+1];
                    frag_len[i] = frag_len[i+1];
                  end
                  frag_count--;
                end else begin
                  frag_start[k] = 32'(st + need);
                  frag_len[k] = 32'(ln - need);
                end
                r.status = lham_pkg::ST_OK;
                r.obj_addr = base + st * 32;
                r.obj_lines = need[12:0];
                break;
              end
            end
          end
        end
        lham_pkg::CMD_FIND, lham_pkg::CMD_MARK: begin
          off = (addr - base) >> 5;
          if (addr < base || off >= u) r.status = lham_pkg::ST_NOT_HEAP;
          else begin
            s = 32'(off);
            while (s > 0 && !heads[s]) s--;
            n = 1;
            for (int unsigned i = s + 1; i < u && !heads[i]; i++) n++;
            r.obj_addr = base + longint'(s) * 32;
            r.obj_lines = n[12:0];
            if (c == lham_pkg::CMD_MARK) begin
              if (marks[s]) r.status = lham_pkg::ST_MARKED;
              else for (int unsigned i = s; i < s + n && i < HEAP_LINES; i++) marks[i] = 1'b1;
            end
          end
        end
        default: begin
          over = 1'b0;
          cnt = 0;
          ln_i = 0;
          while (ln_i < u) begin
            if (marks[ln_i]) ln_i++;
            else begin
              s = ln_i;
              while (ln_i < u && !marks[ln_i]) begin
                heads[ln_i] = 1'b1;
                ln_i++;
              end
              r.free_lines += 13'(ln_i - s);
              if (cnt < MAX_FRAGMENTS) begin
                frag_start[cnt] = s;
                frag_len[cnt] = ln_i - s;
                cnt++;
              end else over = 1'b1;
            end
          end
          frag_count = cnt;
          foreach (marks[i]) marks[i] = 1'b0;
          r.free_frags = cnt[8:0];
          r.status = over ? lham_pkg::ST_OVERFLOW : lham_pkg::ST_OK;
        end
      endcase
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.obj_addr !== e.obj_addr) begin
        $error("object_address: expected %h, got %h", e.obj_addr, got.obj_addr);
        errors++;
      end
      if (got.obj_lines !== e.obj_lines) begin
        $error("object_lines: expected %0d, got %0d", e.obj_lines, got.obj_lines);
        errors++;
      end
      if (got.free_lines !== e.free_lines) begin
        $error("free_lines: expected %0d, got %0d", e.free_lines, got.free_lines);
        errors++;
      end
      if (got.free_frags !== e.free_frags) begin
        $error("free_fragments: expected %0d, got %0d", e.free_frags, got.free_frags);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [31:0] request_bytes_i = '0;
  logic [63:0] address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [63:0] object_address_o;
  logic [12:0] object_lines_o;
  logic [12:0] free_lines_o;
  logic [8:0]  free_fragments_o;

  heap_scoreboard sb = new();
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 53;
  int unsigned hold_cycles = 0;
  int unsigned items_sent = 0;
  logic [63:0] live_ptrs[$];

  line_heap_allocator_marker_unit #(
    .HEAP_LINES(HEAP_LINES),
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .request_bytes_i, .address_i,
    .out_valid_o, .out_ready_i, .status_o, .object_address_o, .object_lines_o,
    .free_lines_o, .free_fragments_o
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  initial begin
    longint unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // result side
  initial begin
    heap_result_t got;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.status = lham_pkg::status_e'(status_o);
        got.obj_addr = object_address_o;
        got.obj_lines = object_lines_o;
        got.free_lines = free_lines_o;
        got.free_frags = free_fragments_o;
        sb.check_result(got);
      end
    end
  end

  task automatic send_cmd(lham_pkg::cmd_e c, logic [31:0] req, logic [63:0] addr);
    heap_result_t r;
    if (items_sent < 220) begin
      send_idle_pct = 23;
      recv_idle_pct = 53;
    end else if (items_sent < 440) begin
      send_idle_pct = 53;
      recv_idle_pct = 23;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = c;
    request_bytes_i = req;
    address_i = addr;
    do @(posedge clk_i); while (!in_ready_o);
    r = sb.note_command(c, req, addr);
    items_sent++;
    if (c == lham_pkg::CMD_ALLOC && r.status == lham_pkg::ST_OK) live_ptrs.push_back(r.obj_addr);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit idx, logic [63:0] data);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [63:0] pick_address();
    int unsigned r;
    logic [63:0] a;
    r = $urandom_range(99);
    if (r < 50 && live_ptrs.size() > 0)
      a = live_ptrs[$urandom_range(live_ptrs.size() - 1)] + $urandom_range(63);
    else if (r < 80)
      a = sb.base + longint'($urandom_range(sb.span() - 1)) * 32 + $urandom_range(31);
    else if (r < 88)
      a = sb.base + longint'(sb.span()) * 32 + $urandom_range(200);
    else if (r < 94)
      a = sb.base - 1 - $urandom_range(100);
    else
      a = {$urandom, $urandom};
    return a;
  endfunction

  task automatic random_cmds(int unsigned count, int unsigned sweep_pct);
    int unsigned r;
    int unsigned q;
    logic [31:0] req;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < sweep_pct) begin
        send_cmd(lham_pkg::CMD_SWEEP, $urandom, {$urandom, $urandom});
        live_ptrs.delete();
      end else if (r < 45) begin
        q = $urandom_range(99);
        if (q < 4) req = '0;
        else if (q < 10) req = $urandom;
        else req = $urandom_range(1, 200);
        send_cmd(lham_pkg::CMD_ALLOC, req, {$urandom, $urandom});
      end else if (r < 75) begin
        send_cmd(lham_pkg::CMD_MARK, $urandom, pick_address());
      end else begin
        send_cmd(lham_pkg::CMD_FIND, $urandom, pick_address());
      end
    end
  endtask

  initial begin
    logic [63:0] b;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset configuration
    send_cmd(lham_pkg::CMD_ALLOC, 32'd0, '0);
    send_cmd(lham_pkg::CMD_ALLOC, 32'd1, '0);
    send_cmd(lham_pkg::CMD_ALLOC, 32'd31, '0);
    send_cmd(lham_pkg::CMD_ALLOC, 32'd32, '0);
    send_cmd(lham_pkg::CMD_ALLOC, 32'd1000, '1);
    send_cmd(lham_pkg::CMD_ALLOC, 32'hFFFF_FFFF, '0);
    send_cmd(lham_pkg::CMD_FIND, '1, 64'd0);
    send_cmd(lham_pkg::CMD_FIND, '0, 64'd100);
    send_cmd(lham_pkg::CMD_FIND, '0, 64'd250);
    send_cmd(lham_pkg::CMD_FIND, '0, 64'(4096 * 32 - 1));
    send_cmd(lham_pkg::CMD_FIND, '0, 64'(4096 * 32));
    send_cmd(lham_pkg::CMD_FIND, '0, '1);
    send_cmd(lham_pkg::CMD_MARK, '0, 64'd0);
    send_cmd(lham_pkg::CMD_MARK, '0, 64'd31);
    send_cmd(lham_pkg::CMD_MARK, '0, 64'd0);
    send_cmd(lham_pkg::CMD_MARK, '0, 64'd100);
    send_cmd(lham_pkg::CMD_MARK, '0, 64'(2000 * 32 + 7));
    send_cmd(lham_pkg::CMD_MARK, '0, '1);
    send_cmd(lham_pkg::CMD_SWEEP, '0, '0);
    send_cmd(lham_pkg::CMD_ALLOC, 32'd130_000, '0);
    send_cmd(lham_pkg::CMD_FIND, '0, 64'd64);
    send_cmd(lham_pkg::CMD_SWEEP, '1, '1);
    live_ptrs.delete();

    write_cfg(1'(lham_pkg::CFG_HEAP_BASE), {$urandom, $urandom});
    write_cfg(1'(lham_pkg::CFG_USABLE_LINES), 64'd1);
    random_cmds(25, 10);

    write_cfg(1'(lham_pkg::CFG_HEAP_BASE), 64'hFFFF_FFFF_FFFF_F800);
    write_cfg(1'(lham_pkg::CFG_USABLE_LINES), 64'd64);
    live_ptrs.delete();
    random_cmds(60, 6);

    write_cfg(1'(lham_pkg::CFG_HEAP_BASE), {$urandom, $urandom});
    write_cfg(1'(lham_pkg::CFG_USABLE_LINES), 64'd200);
    live_ptrs.delete();
    @(negedge clk_i);
    hold_cycles = 400;
    random_cmds(130, 5);

    // fragment overflow: every other line marked as its own object
    b = {$urandom, $urandom} & ~64'h1F;
    write_cfg(1'(lham_pkg::CFG_HEAP_BASE), b);
    write_cfg(1'(lham_pkg::CFG_USABLE_LINES), 64'd520);
    live_ptrs.delete();
    send_cmd(lham_pkg::CMD_SWEEP, '0, '0);
    send_cmd(lham_pkg::CMD_SWEEP, '0, '0);
    for (int j = 0; j < 262; j++) begin
      send_cmd(lham_pkg::CMD_MARK, $urandom, b + longint'(2 * j) * 32 + $urandom_range(31));
      if (j % 12 == 5) send_cmd(lham_pkg::CMD_FIND, $urandom, pick_address());
    end
    send_cmd(lham_pkg::CMD_SWEEP, '0, '0);
    random_cmds(15, 5);

    write_cfg(1'(lham_pkg::CFG_HEAP_BASE), {$urandom, $urandom});
    write_cfg(1'(lham_pkg::CFG_USABLE_LINES), 64'h1FFF);
    live_ptrs.delete();
    random_cmds(30, 1);

    write_cfg(1'(lham_pkg::CFG_HEAP_BASE), '1);
    write_cfg(1'(lham_pkg::CFG_USABLE_LINES), 64'd4096);
    live_ptrs.delete();
    random_cmds(30, 1);

    write_cfg(1'(lham_pkg::CFG_HEAP_BASE), {$urandom, $urandom});
    write_cfg(1'(lham_pkg::CFG_USABLE_LINES), 64'($urandom_range(32, 300)));
    live_ptrs.delete();
    random_cmds(70, 5);

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
